// File: hdl/sfcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcc_pkg
// Shared types, constants and the byte-wide CRC-16/CCITT-FALSE update for the
// sample frame CRC checker.
// ----------------------------------------------------------------------------
package sfcc_pkg;

  localparam int FRAME_BYTES_DEFAULT = 48;

  localparam int POS_W = 6;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam int HDR_LEN = 4;
  localparam logic [7:0] HEADER [HDR_LEN] = '{8'hA5, 8'h5A, 8'h01, 8'h01};

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_HEADER = 2'd2,
    ERR_CRC    = 2'd3
  } err_code_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic        frame_ok;
    err_code_t   error_code;
    logic [15:0] computed_crc;
    logic [15:0] trailer_crc;
  } result_t;

  // MSB-first, one byte per call, unrolled over the eight bit steps
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/sfcc_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcc_track
// Per-frame tracking: byte position, running CRC, header flag and trailing
// CRC low byte, plus the verdict formed on the last byte.
// ----------------------------------------------------------------------------
module sfcc_track #(
  parameter int FRAME_BYTES = sfcc_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  sfcc_pkg::item_t  item,
  output sfcc_pkg::result_t result
);
  import sfcc_pkg::*;

  localparam logic [POS_W-1:0] CRC_POS  = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0] byte_position;
  logic [15:0]      running_crc;
  logic             header_matches;
  logic [7:0]       crc_low_byte;

  logic [POS_W-1:0] byte_position_next;
  logic [15:0]      running_crc_next;
  logic             header_matches_next;
  logic [7:0]       crc_low_byte_next;

  logic             len_ok;
  logic [15:0]      rx_crc;
  err_code_t        code;

  always_comb begin
    header_matches_next = header_matches;
    if (byte_position < POS_W'(HDR_LEN) &&
        item.frame_byte != HEADER[byte_position[1:0]]) begin
      header_matches_next = 1'b0;
    end

    running_crc_next  = running_crc;
    crc_low_byte_next = crc_low_byte;
    if (byte_position < CRC_POS) begin
      running_crc_next = crc_add_byte(running_crc, item.frame_byte);
    end else if (byte_position == CRC_POS) begin
      crc_low_byte_next = item.frame_byte;
    end

    byte_position_next = (byte_position == POS_MAX) ? byte_position
                                                     : byte_position + POS_W'(1);

    len_ok = (byte_position == LAST_POS);
    rx_crc = len_ok ? {item.frame_byte, crc_low_byte_next} : 16'h0000;

    priority if (!len_ok) begin
      code = ERR_LENGTH;
    end else if (!header_matches_next) begin
      code = ERR_HEADER;
    end else if (rx_crc != running_crc_next) begin
      code = ERR_CRC;
    end else begin
      code = ERR_NONE;
    end

    result.frame_ok     = (code == ERR_NONE);
    result.error_code   = code;
    result.computed_crc = running_crc_next;
    result.trailer_crc  = rx_crc;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.is_last)) begin
      byte_position  <= '0;
      running_crc    <= CRC_INIT;
      header_matches <= 1'b1;
      crc_low_byte   <= 8'h00;
    end else if (step) begin
      byte_position  <= byte_position_next;
      running_crc    <= running_crc_next;
      header_matches <= header_matches_next;
      crc_low_byte   <= crc_low_byte_next;
    end
  end

endmodule

// File: hdl/sample_frame_crc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_frame_crc_checker
// Checks fixed-size sample frames (header A5 5A 01 01, little-endian
// CRC-16/CCITT-FALSE trailer) arriving one byte per transaction.
//
// frame_* channel: one byte per transaction, is_last marks the end of frame.
// result_* channel: one verdict per byte that carries is_last, none otherwise.
// Throughput: one byte per cycle unless a last byte stalls; the CRC update
// is a byte-wide unrolled step between the input register and frame state.
// Datapath: a taken byte is registered in the input register, then processed
// into the frame state; a last byte's verdict goes to the result register.
// Stalls: a pending verdict holds in the result register while non-last
// bytes keep flowing; a last byte waits in the input register until the
// result register is free, and frame_ready drops only then.
// Reset: rst (synchronous) empties both registers and returns the frame
// state to position 0, CRC FFFF, header flag set.
// ----------------------------------------------------------------------------
module sample_frame_crc_checker #(
  parameter int FRAME_BYTES = sfcc_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              frame_valid,
  output logic              frame_ready,
  input  sfcc_pkg::item_t   frame_item,
  output logic              result_valid,
  input  logic              result_ready,
  output sfcc_pkg::result_t result
);
  import sfcc_pkg::*;

  logic    item_valid;
  item_t   item_q;
  logic    step;
  logic    out_free;
  result_t verdict;

  assign out_free    = !result_valid || result_ready;
  assign step        = item_valid && (!item_q.is_last || out_free);
  assign frame_ready = !item_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (frame_ready) begin
      item_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      item_q <= frame_item;
    end
  end

  sfcc_track #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_track (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .item  (item_q),
    .result(verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && item_q.is_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && item_q.is_last) begin
      result <= verdict;
    end
  end

endmodule

// File: bench/tb_sample_frame_crc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sample_frame_crc_checker
// Self-checking bench for the sample frame checker. Frames are built in a
// queue: a few short directed frames first, then random frames, well formed
// ones (right header and trailer) most often, mixed with bad-header, bad-CRC,
// short, long and noise frames. A clocked driver feeds the frame channel with
// random gaps; a clocked monitor stalls the result channel at random. Each
// accepted byte updates a local frame tracker that queues the verdict due on
// each last byte, and every verdict from the DUT is checked field by field.
// ----------------------------------------------------------------------------
module tb_sample_frame_crc_checker;
  import sfcc_pkg::*;

  localparam int FRAME_LEN   = 48;
  localparam int ITEM_TARGET = 1700;
  localparam int LONG_MAX    = 80;

  localparam logic [7:0] HDR_PATTERN [4] = '{8'hA5, 8'h5A, 8'h01, 8'h01};

  typedef enum int {
    FR_GOOD,
    FR_BAD_CRC,
    FR_BAD_HDR,
    FR_NOISE,
    FR_SHORT,
    FR_LONG
  } frame_kind_e;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    frame_valid = 1'b0;
  logic    frame_ready;
  item_t   frame_item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  item_t   byte_feed [$];
  result_t verdicts_due [$];
  int      items_queued = 0;
  int      fail_count = 0;

  // frame tracker state
  logic [5:0]  byte_pos = '0;
  logic [15:0] run_crc = 16'hFFFF;
  logic        hdr_ok = 1'b1;
  logic [7:0]  trailer_lo = '0;

  sample_frame_crc_checker #(.FRAME_BYTES(FRAME_LEN)) dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame_item   (frame_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #10 clk = ~clk;

  // bit-serial CRC-16/CCITT-FALSE step, MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c  = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
    end
    return c;
  endfunction

  function automatic void track_frame_byte(input item_t it);
    logic [5:0]  pos;
    logic        len_ok;
    logic [15:0] rx;
    result_t     v;
    pos = byte_pos;
    if (pos < 4 && it.frame_byte != HDR_PATTERN[pos[1:0]]) hdr_ok = 1'b0;
    if (pos < FRAME_LEN - 2) run_crc = crc16_step(run_crc, it.frame_byte);
    else if (pos == FRAME_LEN - 2) trailer_lo = it.frame_byte;
    if (!it.is_last) begin
      if (pos != 6'h3F) byte_pos = pos + 6'd1;
      return;
    end
    len_ok = (pos == FRAME_LEN - 1);
    rx = len_ok ? {it.frame_byte, trailer_lo} : 16'h0000;
    if (!len_ok)           v.error_code = ERR_LENGTH;
    else if (!hdr_ok)      v.error_code = ERR_HEADER;
    else if (rx != run_crc) v.error_code = ERR_CRC;
    else                   v.error_code = ERR_NONE;
    v.frame_ok     = (v.error_code == ERR_NONE);
    v.computed_crc = run_crc;
    v.trailer_crc  = rx;
    verdicts_due.push_back(v);
    byte_pos   = '0;
    run_crc    = 16'hFFFF;
    hdr_ok     = 1'b1;
    trailer_lo = '0;
  endfunction

  task automatic queue_bytes(input logic [7:0] bytes [$]);
    item_t it;
    for (int i = 0; i < bytes.size(); i++) begin
      it.frame_byte = bytes[i];
      it.is_last    = (i == bytes.size() - 1);
      byte_feed.push_back(it);
    end
    items_queued += bytes.size();
  endtask

  task automatic queue_frame(input frame_kind_e kind);
    logic [7:0]  bytes [$];
    logic [15:0] c;
    int          n;
    int          idx;
    bytes = {};
    c = 16'hFFFF;
    case (kind)
      FR_NOISE: begin
        n = FRAME_LEN;
        for (int i = 0; i < n; i++) bytes.push_back(8'($urandom_range(0, 255)));
      end
      FR_SHORT: begin
        n = ($urandom_range(0, 3) == 0) ? FRAME_LEN - 1 : $urandom_range(1, FRAME_LEN - 1);
        for (int i = 0; i < n; i++) begin
          if (i < 4 && $urandom_range(0, 1)) bytes.push_back(HDR_PATTERN[i]);
          else bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) bytes.push_back(HDR_PATTERN[i]);
        for (int i = 4; i < FRAME_LEN - 2; i++) bytes.push_back(8'($urandom_range(0, 255)));
        if (kind == FR_BAD_HDR) begin
          idx = $urandom_range(0, 3);
          bytes[idx] = bytes[idx] ^ 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < FRAME_LEN - 2; i++) c = crc16_step(c, bytes[i]);
        bytes.push_back(c[7:0]);
        bytes.push_back(c[15:8]);
        if (kind == FR_BAD_CRC) begin
          idx = FRAME_LEN - 2 + $urandom_range(0, 1);
          bytes[idx] = bytes[idx] ^ 8'($urandom_range(1, 255));
        end
        if (kind == FR_LONG) begin
          n = ($urandom_range(0, 3) == 0) ? FRAME_LEN + 1 : $urandom_range(FRAME_LEN + 1, LONG_MAX);
          while (bytes.size() < n) bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
    endcase
    queue_bytes(bytes);
  endtask

  // frame channel driver
  int drive_gap = 0;
  int drive_count = 0;
  bit drive_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      drive_gap = 0;
    end else begin
      if (frame_valid && frame_ready) track_frame_byte(frame_item);
      if (!frame_valid || frame_ready) begin
        if (drive_gap > 0 || byte_feed.size() == 0) begin
          if (drive_gap > 0) drive_gap--;
          frame_valid <= 1'b0;
        end else begin
          frame_item  <= byte_feed.pop_front();
          frame_valid <= 1'b1;
          drive_count++;
          if (drive_count % 128 == 0) drive_calm = ($urandom_range(0, 3) == 0);
          drive_gap = drive_calm ? 0 : $urandom_range(0, 4);
        end
      end
    end
  end

  // result channel monitor
  int      sink_stall = 0;
  int      sink_count = 0;
  bit      sink_calm = 1'b0;
  result_t want;

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected result transaction: %h", result);
          fail_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (result.frame_ok !== want.frame_ok) begin
            $error("frame_ok: expected %0d, actual %0d", want.frame_ok, result.frame_ok);
            fail_count++;
          end
          if (result.error_code !== want.error_code) begin
            $error("error_code: expected %0d, actual %0d", want.error_code, result.error_code);
            fail_count++;
          end
          if (result.computed_crc !== want.computed_crc) begin
            $error("computed_crc: expected %h, actual %h", want.computed_crc,
                   result.computed_crc);
            fail_count++;
          end
          if (result.trailer_crc !== want.trailer_crc) begin
            $error("trailer_crc: expected %h, actual %h", want.trailer_crc,
                   result.trailer_crc);
            fail_count++;
          end
        end
        sink_count++;
        if (sink_count % 16 == 0) sink_calm = ($urandom_range(0, 3) == 0);
        sink_stall = sink_calm ? 0 : $urandom_range(0, 4);
      end else if (sink_stall > 0) begin
        sink_stall--;
      end
      result_ready <= (sink_stall == 0);
    end
  end

  initial begin
    frame_kind_e kind;
    int          frames;
    // directed short frames: extremes of the byte, header fragments, lone bytes
    queue_bytes({8'h00});
    queue_bytes({8'hFF});
    queue_bytes({8'hA5, 8'h5A, 8'h01, 8'h01});
    queue_bytes({8'hA5, 8'h5A, 8'h00});
    queue_bytes({8'hA5, 8'h5A, 8'h01, 8'h01, 8'hFF, 8'h00});
    queue_bytes({8'h5A});
    // random part: every frame kind once, then a weighted mix
    frames = 0;
    while (items_queued < ITEM_TARGET) begin
      if (frames < 6) begin
        kind = frame_kind_e'(frames);
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6: kind = FR_GOOD;
          7, 8, 9:             kind = FR_BAD_CRC;
          10, 11:              kind = FR_BAD_HDR;
          12, 13, 14:          kind = FR_SHORT;
          15, 16:              kind = FR_LONG;
          default:             kind = FR_NOISE;
        endcase
      end
      queue_frame(kind);
      frames++;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (byte_feed.size() != 0 || frame_valid || verdicts_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
hdl/sfcc_pkg.sv
hdl/sfcc_track.sv
hdl/sample_frame_crc_checker.sv
bench/tb_sample_frame_crc_checker.sv
